FILE: hw/rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear probing hash set: table geometry,
// request and result codes, slot states, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package lphs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int CNT_W       = $clog2(KEY_WIDTH);

    // request types
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // result codes
    localparam logic [1:0] RC_INSERTED = 2'd0;
    localparam logic [1:0] RC_FULL     = 2'd1;
    localparam logic [1:0] RC_HIT      = 2'd2;
    localparam logic [1:0] RC_MISS     = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_UNUSED = 2'd0;
    localparam logic [1:0] SLOT_INUSE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB   = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]           req_type;
        logic [KEY_WIDTH-1:0] key_value;
    } t_lphs_req;

    // result payload
    typedef struct packed {
        logic [1:0]        result_code;
        logic [IDX_W-1:0]  slot_index;
        logic [SIZE_W-1:0] removed_count;
        logic [SIZE_W-1:0] occupied_count;
    } t_lphs_rsp;

    // slot store access
    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W-1:0]     addr;
        logic                 status_we;
        logic [1:0]           status_wdata;
        logic                 key_we;
        logic [KEY_WIDTH-1:0] key_wdata;
    } t_lphs_store_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL
    } t_lphs_state;

endpackage

FILE: hw/rtl/lphs_div.sv
// ----------------------------------------------------------------------------
// lphs_div
// Bit-serial restoring remainder unit: key modulo table size, one key bit
// per cycle, done pulse in the cycle after the last step.
// ----------------------------------------------------------------------------
module lphs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lphs_pkg::KEY_WIDTH-1:0]   i_dividend,
    input  logic [lphs_pkg::SIZE_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [lphs_pkg::IDX_W-1:0]       o_rem
);
    import lphs_pkg::*;

    logic                 r_run, n_run;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [KEY_WIDTH-1:0] r_dvd, n_dvd;
    logic [SIZE_W-1:0]    r_dvs, n_dvs;
    logic [SIZE_W-1:0]    r_rem, n_rem;
    logic [SIZE_W-1:0]    trial;

    // one shift, compare and subtract step
    always_comb begin
        trial  = {r_rem[SIZE_W-2:0], r_dvd[KEY_WIDTH-1]};
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_dvd = i_dividend;
            n_dvs = i_divisor;
            n_rem = '0;
        end else if (r_run) begin
            n_rem = (trial >= r_dvs) ? (trial - r_dvs) : trial;
            n_dvd = {r_dvd[KEY_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(KEY_WIDTH - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IDX_W-1:0];

endmodule

FILE: hw/rtl/lphs_store.sv
// ----------------------------------------------------------------------------
// lphs_store
// Slot store: status memory and key memory sharing one address, one access
// per cycle, registered read data.
// ----------------------------------------------------------------------------
module lphs_store (
    input  logic                             i_clk,
    input  lphs_pkg::t_lphs_store_req        i_req,
    output logic [1:0]                       o_status,
    output logic [lphs_pkg::KEY_WIDTH-1:0]   o_key
);
    import lphs_pkg::*;

    logic [1:0]           status_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] key_mem    [TABLE_DEPTH];
    logic [1:0]           r_status;
    logic [KEY_WIDTH-1:0] r_key;

    // status memory
    always_ff @(posedge i_clk) begin
        if (i_req.status_we) begin
            status_mem[i_req.addr] <= i_req.status_wdata;
        end
        if (i_req.rd_en) begin
            r_status <= status_mem[i_req.addr];
        end
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (i_req.key_we) begin
            key_mem[i_req.addr] <= i_req.key_wdata;
        end
        if (i_req.rd_en) begin
            r_key <= key_mem[i_req.addr];
        end
    end

    assign o_status = r_status;
    assign o_key    = r_key;

endmodule

FILE: hw/rtl/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing set of keys with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot store to unused, one slot per cycle,
// and holds busy high while it sweeps all 1024 slots; table_size writes are
// taken during the sweep. A request is taken when start is high and busy is
// low. Insert, erase and find first compute the home slot with a bit-serial
// remainder unit, then walk the slots, each slot examined with one memory
// read and then one compare and update; request type 3 answers without the
// remainder unit or the walk. The result is shown for one cycle with
// o_result_valid in the cycle after the last step, and busy is already low in
// that cycle. The receiver cannot stall results.
module linear_probe_hash_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  lphs_pkg::t_lphs_req           i_req,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [lphs_pkg::SIZE_W-1:0]   i_cfg_wdata,
    output logic                          o_result_valid,
    output lphs_pkg::t_lphs_rsp           o_rsp
);
    import lphs_pkg::*;

    t_lphs_state          r_state, n_state;
    logic [SIZE_W-1:0]    r_table_size;
    logic [SIZE_W-1:0]    r_used, n_used;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [1:0]           r_op, n_op;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [IDX_W-1:0]     r_home, n_home;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_first, n_first;
    logic                 r_hit, n_hit;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [SIZE_W-1:0]    r_removed, n_removed;
    logic                 r_valid, n_valid;
    t_lphs_rsp            r_rsp, n_rsp;

    logic                 accept;
    logic [SIZE_W-1:0]    act_size;
    logic                 div_start, div_done;
    logic [IDX_W-1:0]     div_rem;
    t_lphs_store_req      st_req;
    logic [1:0]           rd_status;
    logic [KEY_WIDTH-1:0] rd_key;

    logic [SIZE_W-1:0]    idx_inc;
    logic [IDX_W-1:0]     nxt;
    logic                 e_wrap, e_match, e_stop, e_claim, e_kill, e_finish;
    logic [1:0]           e_code;
    logic [IDX_W-1:0]     e_slot;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // table size in effect: zero acts as one, clamp at depth
    always_comb begin
        if (r_table_size == '0) begin
            act_size = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(TABLE_DEPTH)) begin
            act_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            act_size = r_table_size;
        end
    end

    // home slot unit
    assign div_start = accept && (i_req.req_type != OP_NONE);

    lphs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.key_value),
        .i_divisor  (act_size),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    lphs_store u_store (
        .i_clk    (i_clk),
        .i_req    (st_req),
        .o_status (rd_status),
        .o_key    (rd_key)
    );

    // probe step decode
    always_comb begin
        idx_inc  = {1'b0, r_idx} + 1'b1;
        nxt      = (idx_inc >= r_size) ? '0 : idx_inc[IDX_W-1:0];
        e_wrap   = (nxt == r_home);
        e_match  = (rd_status == SLOT_INUSE) && (rd_key == r_key);
        e_stop   = (r_op != OP_INSERT) && !r_first && (rd_status == SLOT_UNUSED);
        e_claim  = (r_op == OP_INSERT) && (rd_status != SLOT_INUSE);
        e_kill   = (r_op == OP_ERASE) && e_match && !e_stop;
        e_finish = 1'b0;
        e_code   = RC_MISS;
        e_slot   = '0;
        case (r_op)
            OP_INSERT: begin
                e_finish = e_claim || e_wrap;
                e_code   = e_claim ? RC_INSERTED : RC_FULL;
                e_slot   = e_claim ? r_idx : '0;
            end
            OP_ERASE: begin
                e_finish = e_stop || e_wrap;
                e_code   = (r_hit || e_kill) ? RC_HIT : RC_MISS;
                e_slot   = r_hit ? r_slot : (e_kill ? r_idx : '0);
            end
            OP_FIND: begin
                e_finish = e_stop || e_match || e_wrap;
                e_code   = (e_match && !e_stop) ? RC_HIT : RC_MISS;
                e_slot   = (e_match && !e_stop) ? r_idx : '0;
            end
            default: begin
                e_finish = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == IDX_W'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (div_start) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = e_finish ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // slot store controls
    always_comb begin
        st_req              = '0;
        st_req.key_wdata    = r_key;
        st_req.addr         = r_idx;
        case (r_state)
            ST_CLEAR: begin
                st_req.addr         = r_clr_idx;
                st_req.status_we    = 1'b1;
                st_req.status_wdata = SLOT_UNUSED;
            end
            ST_READ: begin
                st_req.rd_en = 1'b1;
            end
            ST_EVAL: begin
                if (e_claim) begin
                    st_req.status_we    = 1'b1;
                    st_req.status_wdata = SLOT_INUSE;
                    st_req.key_we       = 1'b1;
                end else if (e_kill) begin
                    st_req.status_we    = 1'b1;
                    st_req.status_wdata = SLOT_TOMB;
                end
            end
            default: begin
                st_req.rd_en = 1'b0;
            end
        endcase
    end

    // request context and result
    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_size    = r_size;
        n_home    = r_home;
        n_idx     = r_idx;
        n_first   = r_first;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_removed = r_removed;
        n_used    = r_used;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        if (accept) begin
            n_op      = i_req.req_type;
            n_key     = i_req.key_value;
            n_size    = act_size;
            n_hit     = 1'b0;
            n_slot    = '0;
            n_removed = '0;
            if (i_req.req_type == OP_NONE) begin
                n_valid = 1'b1;
                n_rsp   = '{RC_MISS, '0, '0, r_used};
            end
        end
        if ((r_state == ST_DIV) && div_done) begin
            n_home  = div_rem;
            n_idx   = div_rem;
            n_first = 1'b1;
        end
        if (r_state == ST_EVAL) begin
            n_first = 1'b0;
            n_idx   = nxt;
            if (e_claim) n_used = r_used + 1'b1;
            if (e_kill) begin
                n_used    = r_used - 1'b1;
                n_removed = r_removed + 1'b1;
                n_hit     = 1'b1;
                if (!r_hit) n_slot = r_idx;
            end
            if (e_finish) begin
                n_valid = 1'b1;
                n_rsp   = '{e_code, e_slot, n_removed, n_used};
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_table_size <= SIZE_W'(3);
            r_used       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cfg_we) r_table_size <= i_cfg_wdata;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_size    <= n_size;
        r_home    <= n_home;
        r_idx     <= n_idx;
        r_first   <= n_first;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_removed <= n_removed;
        r_rsp     <= n_rsp;
    end

    assign o_result_valid = r_valid;
    assign o_rsp          = r_rsp;

    // checks
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while sequencer busy");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SIZE_W'(TABLE_DEPTH))
        else $error("occupied count above depth");

    a_walk_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV))
        else $error("accepted request did not start home slot unit");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_rsp.result_code == RC_FULL)) |-> (o_rsp.slot_index == '0))
        else $error("full result carries a slot index");

endmodule
